/* design/axr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation package
// Shared constants, the request side-band type and the CORDIC angle steps.
// ----------------------------------------------------------------------------
package axr_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int NORM_STEPS     = 5;
   localparam int SQRT_STEPS     = 32;
   localparam int DIV_STEPS      = 31;
   localparam int CORDIC_STEPS   = 28;

   localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;
   localparam logic signed [31:0] PI_Q28          = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28     = 32'sd421657428;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic                     zero;
      logic                     flip;
      logic [2:0]               neg;
      logic [2:0][31:0]         mag;
      logic signed [31:0]       ang;
   } side_type;

   function automatic logic signed [31:0] atan_step(input int idx);
      logic signed [31:0] v;
      case (idx)
         0: v = 32'sd210828714;
         1: v = 32'sd124459457;
         2: v = 32'sd65760959;
         3: v = 32'sd33381290;
         4: v = 32'sd16755422;
         5: v = 32'sd8385879;
         6: v = 32'sd4193963;
         7: v = 32'sd2097109;
         8: v = 32'sd1048571;
         9: v = 32'sd524287;
         default: v = 32'sd1 <<< (28 - idx);
      endcase
      return v;
   endfunction

endpackage

/* design/axr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation channels
// Request channel (axis and angle) and response channel (rotation matrix).
// ----------------------------------------------------------------------------
interface axr_req_if import axr_pkg::*; #(parameter int WORD_WIDTH = WORD_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] axis_x;
   logic signed [WORD_WIDTH-1:0] axis_y;
   logic signed [WORD_WIDTH-1:0] axis_z;
   logic signed [WORD_WIDTH-2:0] rot_angle;
   modport source(output valid, axis_x, axis_y, axis_z, rot_angle, input ready);
   modport sink(input valid, axis_x, axis_y, axis_z, rot_angle, output ready);
endinterface

interface axr_rsp_if import axr_pkg::*; #(parameter int WORD_WIDTH = WORD_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] m00;
   logic signed [WORD_WIDTH-1:0] m01;
   logic signed [WORD_WIDTH-1:0] m02;
   logic signed [WORD_WIDTH-1:0] m10;
   logic signed [WORD_WIDTH-1:0] m11;
   logic signed [WORD_WIDTH-1:0] m12;
   logic signed [WORD_WIDTH-1:0] m20;
   logic signed [WORD_WIDTH-1:0] m21;
   logic signed [WORD_WIDTH-1:0] m22;
   logic                         zero_axis;
   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_axis,
                  input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_axis,
                output ready);
endinterface

/* design/axr_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the floor square root of the sum of squares.
// ----------------------------------------------------------------------------
module axr_sqrt_cell import axr_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] up_rem,
   input  logic [31:0] up_root,
   input  side_type    up_side,
   output logic [63:0] dn_rem,
   output logic [31:0] dn_root,
   output side_type    dn_side
);

   logic [65:0] trial;
   logic [63:0] rem_in;
   logic [31:0] root_in;
   logic [63:0] rem_ff;
   logic [31:0] root_ff;
   side_type    side_ff;

   always_comb begin
      trial   = (66'(up_root) << (BIT + 1)) + (66'd1 << (2 * BIT));
      rem_in  = up_rem;
      root_in = up_root;
      if ({2'b00, up_rem} >= trial) begin
         rem_in  = up_rem - trial[63:0];
         root_in = up_root | (32'd1 << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_side = side_ff;

endmodule

/* design/axr_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit of each of the three axis divisions by the length.
// ----------------------------------------------------------------------------
module axr_div_cell import axr_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [2:0][61:0] up_rem,
   input  logic [2:0][30:0] up_quo,
   input  logic [31:0]      up_div,
   input  side_type         up_side,
   output logic [2:0][61:0] dn_rem,
   output logic [2:0][30:0] dn_quo,
   output logic [31:0]      dn_div,
   output side_type         dn_side
);

   logic [62:0]      div_sh;
   logic [2:0][61:0] rem_in;
   logic [2:0][30:0] quo_in;
   logic [2:0][61:0] rem_ff;
   logic [2:0][30:0] quo_ff;
   logic [31:0]      div_ff;
   side_type         side_ff;

   always_comb begin
      div_sh = 63'(up_div) << BIT;
      for (int k = 0; k < 3; k++) begin
         rem_in[k] = up_rem[k];
         quo_in[k] = up_quo[k];
         if ({1'b0, up_rem[k]} >= div_sh) begin
            rem_in[k] = up_rem[k] - div_sh[61:0];
            quo_in[k] = up_quo[k] | (31'd1 << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= up_div;
         side_ff <= up_side;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_quo  = quo_ff;
   assign dn_div  = div_ff;
   assign dn_side = side_ff;

endmodule

/* design/axr_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step of the sine and cosine evaluation.
// ----------------------------------------------------------------------------
module axr_cordic_cell import axr_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] up_x,
   input  logic signed [33:0] up_y,
   input  logic signed [31:0] up_z,
   input  side_type           up_side,
   output logic signed [33:0] dn_x,
   output logic signed [33:0] dn_y,
   output logic signed [31:0] dn_z,
   output side_type           dn_side
);

   logic signed [31:0] step;
   logic signed [33:0] x_in;
   logic signed [33:0] y_in;
   logic signed [31:0] z_in;
   logic signed [33:0] x_ff;
   logic signed [33:0] y_ff;
   logic signed [31:0] z_ff;
   side_type           side_ff;

   always_comb begin
      step = atan_step(IDX);
      if (!up_z[31]) begin
         x_in = up_x - (up_y >>> IDX);
         y_in = up_y + (up_x >>> IDX);
         z_in = up_z - step;
      end else begin
         x_in = up_x + (up_y >>> IDX);
         y_in = up_y - (up_x >>> IDX);
         z_in = up_z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= up_side;
      end
   end

   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_z    = z_ff;
   assign dn_side = side_ff;

endmodule

/* design/axis_angle_to_rotation_matrix_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle to rotation matrix
// Rodrigues rotation formula in fixed point over a chain of pipeline cells.
// ----------------------------------------------------------------------------
//   channel | direction | contents
//   req     | in        | axis_x, axis_y, axis_z, rot_angle
//   rsp     | out       | m00 .. m22, zero_axis
//
// One request enters per cycle while the response is not stalled; each result
// passes through the input stage, 5 normalizing stages, 2 squaring stages, the
// 32 square root cells, 31 division cells, 28 CORDIC cells and 4 output stages.
// Reset clears only the valid bits of the pipeline.
// A stalled response freezes the whole pipeline, so no request is lost.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix_top import axr_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input logic     clock,
   input logic     reset,
   axr_req_if.sink   req,
   axr_rsp_if.source rsp
);

   localparam int DN  = (WORD_WIDTH >= 32) ? WORD_WIDTH - 32 : 0;
   localparam int UP  = (WORD_WIDTH < 32) ? 32 - WORD_WIDTH : 0;
   localparam logic signed [63:0] RND = (64'sd1 <<< UP) >>> 1;
   localparam int LAT = 1 + NORM_STEPS + 2 + SQRT_STEPS + DIV_STEPS + CORDIC_STEPS + 4;

   function automatic logic signed [31:0] to_q28(input logic signed [63:0] v);
      logic signed [63:0] s;
      s = (v >>> DN) <<< UP;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      p = (p + 64'sd536870912) >>> 30;
      return p[31:0];
   endfunction

   function automatic logic signed [33:0] mulq_t(input logic signed [31:0] a,
                                                 input logic signed [32:0] b);
      logic signed [63:0] p;
      p = a * b;
      p = (p + 64'sd536870912) >>> 30;
      return p[33:0];
   endfunction

   function automatic logic [WORD_WIDTH-1:0] emit(input logic signed [34:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      if (e > 64'(ONE_Q30)) begin
         e = 64'(ONE_Q30);
      end else if (e < -64'(ONE_Q30)) begin
         e = -64'(ONE_Q30);
      end
      e = ((e + RND) >>> UP) <<< DN;
      return e[WORD_WIDTH-1:0];
   endfunction

   logic           adv;
   logic [LAT-1:0] vld_in;
   logic [LAT-1:0] vld_ff;

   assign adv       = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;
   assign vld_in    = {vld_ff[LAT-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Input stage: format conversion, zero detection, magnitudes, angle clamping and folding.
   logic signed [2:0][31:0] ax;
   logic signed [31:0]      ang;
   side_type                in_side;
   side_type                s0_ff;

   always_comb begin
      ax[0] = to_q28(64'(req.axis_x));
      ax[1] = to_q28(64'(req.axis_y));
      ax[2] = to_q28(64'(req.axis_z));
      ang   = to_q28(64'(req.rot_angle));
      in_side.zero = (ax[0] == 32'sd0) && (ax[1] == 32'sd0) && (ax[2] == 32'sd0);
      for (int k = 0; k < 3; k++) begin
         in_side.neg[k] = ax[k][31];
         in_side.mag[k] = ax[k][31] ? 32'(-ax[k]) : 32'(ax[k]);
      end
      if (ang > PI_Q28) begin
         ang = PI_Q28;
      end else if (ang < -PI_Q28) begin
         ang = -PI_Q28;
      end
      in_side.flip = 1'b0;
      if (ang > HALF_PI_Q28) begin
         ang          = ang - PI_Q28;
         in_side.flip = 1'b1;
      end else if (ang < -HALF_PI_Q28) begin
         ang          = ang + PI_Q28;
         in_side.flip = 1'b1;
      end
      in_side.ang = ang;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= in_side;
      end
   end

   // Normalizing shift: the largest magnitude, if nonzero, is brought into [2^30, 2^31].
   side_type nm_side [NORM_STEPS+1];
   assign nm_side[0] = s0_ff;

   for (genvar n = 0; n < NORM_STEPS; n++) begin : g_norm
      localparam int SH = 16 >> n;
      logic [31:0] mag_or;
      side_type    nm_in;
      side_type    nm_ff;
      always_comb begin
         nm_in  = nm_side[n];
         mag_or = nm_side[n].mag[0] | nm_side[n].mag[1] | nm_side[n].mag[2];
         if ((mag_or >> (31 - SH)) == 32'd0) begin
            for (int k = 0; k < 3; k++) begin
               nm_in.mag[k] = nm_side[n].mag[k] << SH;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            nm_ff <= nm_in;
         end
      end
      assign nm_side[n+1] = nm_ff;
   end

   // Squares and their sum.
   logic [2:0][63:0] sq_ff;
   side_type         sq_side_ff;
   logic [63:0]      sum_ff;
   side_type         sum_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= 64'(nm_side[NORM_STEPS].mag[k]) * 64'(nm_side[NORM_STEPS].mag[k]);
         end
         sq_side_ff  <= nm_side[NORM_STEPS];
         sum_ff      <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         sum_side_ff <= sq_side_ff;
      end
   end

   // Square root chain.
   logic [63:0] rt_rem  [SQRT_STEPS+1];
   logic [31:0] rt_root [SQRT_STEPS+1];
   side_type    rt_side [SQRT_STEPS+1];

   assign rt_rem[0]  = sum_ff;
   assign rt_root[0] = 32'd0;
   assign rt_side[0] = sum_side_ff;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      axr_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_cell (
         .clock   (clock),
         .en      (adv),
         .up_rem  (rt_rem[j]),
         .up_root (rt_root[j]),
         .up_side (rt_side[j]),
         .dn_rem  (rt_rem[j+1]),
         .dn_root (rt_root[j+1]),
         .dn_side (rt_side[j+1])
      );
   end

   // Division chain: each component times 2^30 over the length, rounded.
   logic [2:0][61:0] dv_rem  [DIV_STEPS+1];
   logic [2:0][30:0] dv_quo  [DIV_STEPS+1];
   logic [31:0]      dv_div  [DIV_STEPS+1];
   side_type         dv_side [DIV_STEPS+1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dv_rem[0][k] = (62'(rt_side[SQRT_STEPS].mag[k]) << 30)
                      + 62'(rt_root[SQRT_STEPS] >> 1);
      end
   end
   assign dv_quo[0]  = '0;
   assign dv_div[0]  = rt_root[SQRT_STEPS];
   assign dv_side[0] = rt_side[SQRT_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      axr_div_cell #(.BIT(DIV_STEPS - 1 - j)) u_cell (
         .clock   (clock),
         .en      (adv),
         .up_rem  (dv_rem[j]),
         .up_quo  (dv_quo[j]),
         .up_div  (dv_div[j]),
         .up_side (dv_side[j]),
         .dn_rem  (dv_rem[j+1]),
         .dn_quo  (dv_quo[j+1]),
         .dn_div  (dv_div[j+1]),
         .dn_side (dv_side[j+1])
      );
   end

   // CORDIC chain; the side band now carries the unit vector magnitudes.
   logic signed [33:0] cd_x    [CORDIC_STEPS+1];
   logic signed [33:0] cd_y    [CORDIC_STEPS+1];
   logic signed [31:0] cd_z    [CORDIC_STEPS+1];
   side_type           cd_side [CORDIC_STEPS+1];

   always_comb begin
      cd_side[0] = dv_side[DIV_STEPS];
      for (int k = 0; k < 3; k++) begin
         cd_side[0].mag[k] = 32'(dv_quo[DIV_STEPS][k]);
      end
   end
   assign cd_x[0] = CORDIC_GAIN_Q30;
   assign cd_y[0] = 34'sd0;
   assign cd_z[0] = dv_side[DIV_STEPS].ang;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      axr_cordic_cell #(.IDX(j)) u_cell (
         .clock   (clock),
         .en      (adv),
         .up_x    (cd_x[j]),
         .up_y    (cd_y[j]),
         .up_z    (cd_z[j]),
         .up_side (cd_side[j]),
         .dn_x    (cd_x[j+1]),
         .dn_y    (cd_y[j+1]),
         .dn_z    (cd_z[j+1]),
         .dn_side (cd_side[j+1])
      );
   end

   // Post stage: signed unit vector, clamped cosine and sine.
   logic signed [33:0]      xf;
   logic signed [33:0]      yf;
   logic signed [31:0]      c_in;
   logic signed [31:0]      s_in;
   logic signed [2:0][31:0] u_in;
   logic signed [2:0][31:0] u_ff;
   logic signed [31:0]      c_ff;
   logic signed [31:0]      s_ff;
   logic                    z1_ff;

   always_comb begin
      xf = cd_side[CORDIC_STEPS].flip ? -cd_x[CORDIC_STEPS] : cd_x[CORDIC_STEPS];
      yf = cd_side[CORDIC_STEPS].flip ? -cd_y[CORDIC_STEPS] : cd_y[CORDIC_STEPS];
      if (xf > 34'(ONE_Q30)) begin
         c_in = ONE_Q30;
      end else if (xf < -34'(ONE_Q30)) begin
         c_in = -ONE_Q30;
      end else begin
         c_in = xf[31:0];
      end
      if (yf > 34'(ONE_Q30)) begin
         s_in = ONE_Q30;
      end else if (yf < -34'(ONE_Q30)) begin
         s_in = -ONE_Q30;
      end else begin
         s_in = yf[31:0];
      end
      for (int k = 0; k < 3; k++) begin
         u_in[k] = cd_side[CORDIC_STEPS].neg[k] ? -signed'(cd_side[CORDIC_STEPS].mag[k])
                                                : signed'(cd_side[CORDIC_STEPS].mag[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff  <= u_in;
         c_ff  <= c_in;
         s_ff  <= s_in;
         z1_ff <= cd_side[CORDIC_STEPS].zero;
      end
   end

   // First products: outer product terms and sine terms.
   logic signed [5:0][31:0] p_ff;
   logic signed [2:0][31:0] q_ff;
   logic signed [32:0]      t_ff;
   logic signed [31:0]      c2_ff;
   logic                    z2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= mulq(u_ff[0], u_ff[0]);
         p_ff[1] <= mulq(u_ff[1], u_ff[1]);
         p_ff[2] <= mulq(u_ff[2], u_ff[2]);
         p_ff[3] <= mulq(u_ff[0], u_ff[1]);
         p_ff[4] <= mulq(u_ff[0], u_ff[2]);
         p_ff[5] <= mulq(u_ff[1], u_ff[2]);
         for (int k = 0; k < 3; k++) begin
            q_ff[k] <= mulq(u_ff[k], s_ff);
         end
         t_ff  <= 33'(ONE_Q30) - 33'(c_ff);
         c2_ff <= c_ff;
         z2_ff <= z1_ff;
      end
   end

   // Second products: scaling by one minus cosine.
   logic signed [5:0][33:0] r_ff;
   logic signed [2:0][31:0] q2_ff;
   logic signed [31:0]      c3_ff;
   logic                    z3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 6; k++) begin
            r_ff[k] <= mulq_t(p_ff[k], t_ff);
         end
         q2_ff <= q_ff;
         c3_ff <= c2_ff;
         z3_ff <= z2_ff;
      end
   end

   // Matrix assembly and output register.
   logic [8:0][WORD_WIDTH-1:0] m_in;
   logic [8:0][WORD_WIDTH-1:0] m_ff;
   logic                       zero_ff;

   always_comb begin
      if (z3_ff) begin
         for (int k = 0; k < 9; k++) begin
            m_in[k] = emit(((k % 4) == 0) ? 35'(ONE_Q30) : 35'sd0);
         end
      end else begin
         m_in[0] = emit(35'(c3_ff) + 35'(signed'(r_ff[0])));
         m_in[4] = emit(35'(c3_ff) + 35'(signed'(r_ff[1])));
         m_in[8] = emit(35'(c3_ff) + 35'(signed'(r_ff[2])));
         m_in[1] = emit(35'(signed'(r_ff[3])) - 35'(signed'(q2_ff[2])));
         m_in[3] = emit(35'(signed'(r_ff[3])) + 35'(signed'(q2_ff[2])));
         m_in[2] = emit(35'(signed'(r_ff[4])) + 35'(signed'(q2_ff[1])));
         m_in[6] = emit(35'(signed'(r_ff[4])) - 35'(signed'(q2_ff[1])));
         m_in[5] = emit(35'(signed'(r_ff[5])) - 35'(signed'(q2_ff[0])));
         m_in[7] = emit(35'(signed'(r_ff[5])) + 35'(signed'(q2_ff[0])));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff    <= m_in;
         zero_ff <= z3_ff;
      end
   end

   assign rsp.valid     = vld_ff[LAT-1];
   assign rsp.m00       = m_ff[0];
   assign rsp.m01       = m_ff[1];
   assign rsp.m02       = m_ff[2];
   assign rsp.m10       = m_ff[3];
   assign rsp.m11       = m_ff[4];
   assign rsp.m12       = m_ff[5];
   assign rsp.m20       = m_ff[6];
   assign rsp.m21       = m_ff[7];
   assign rsp.m22       = m_ff[8];
   assign rsp.zero_axis = zero_ff;

endmodule
